[design/kcec_pkg.sv]
// ----------------------------------------------------------------------------
// kcec_pkg
// Shared types and constants for the keypad code entry checker.
// ----------------------------------------------------------------------------
`default_nettype none

package kcec_pkg;

  localparam int ENTRY_BUFFER_SIZE = 16;
  localparam int MAX_CODE_CHARS    = 15;
  // usable entries: one slot of the buffer stays free, never more than 15
  localparam int CAPACITY = (ENTRY_BUFFER_SIZE - 1 > MAX_CODE_CHARS) ?
                            MAX_CODE_CHARS : ENTRY_BUFFER_SIZE - 1;

  localparam int KEY_W   = 8;
  localparam int CNT_W   = 4;
  localparam int TICK_W  = 20;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CODE_W  = MAX_CODE_CHARS * KEY_W;

  localparam logic [KEY_W-1:0]  KEY_NONE    = 8'h00;
  localparam logic [KEY_W-1:0]  KEY_DELETE  = 8'h2A;
  localparam logic [KEY_W-1:0]  KEY_CONFIRM = 8'h23;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 20'd10000;
  localparam logic [CNT_W-1:0]  CAPACITY_CNT = CAPACITY[CNT_W-1:0];

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODE_FIRST = 2'd0,
    CFG_CODE_REST  = 2'd1,
    CFG_CODE_LEN   = 2'd2,
    CFG_TIMEOUT    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OUT_MATCH    = 2'd0,
    OUT_MISMATCH = 2'd1,
    OUT_TIMEOUT  = 2'd2
  } outcome_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_HOLD = 1'b1
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic     append;
    logic     delete_char;
    logic     tick;
    logic     clear_attempt;
    logic     load_result;
    outcome_e result;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic timeout_hit;
    logic code_match;
    logic buf_full;
    logic buf_empty;
  } stat_t;

endpackage

`default_nettype wire

[design/kcec_dp.sv]
// ----------------------------------------------------------------------------
// kcec_dp
// Datapath: config registers, entry buffer, counters, compare, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kcec_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [kcec_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [kcec_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire logic [kcec_pkg::KEY_W-1:0]       key_i,
  input  wire kcec_pkg::cmd_t                   cmd_i,
  output kcec_pkg::stat_t                       stat_o,
  output logic [1:0]                            outcome_o
);

  logic [kcec_pkg::CODE_W-1:0]  code_q;
  logic [kcec_pkg::CNT_W-1:0]   code_len_q;
  logic [kcec_pkg::TICK_W-1:0]  timeout_q;
  logic [kcec_pkg::KEY_W-1:0]   entry_q [kcec_pkg::MAX_CODE_CHARS];
  logic [kcec_pkg::CNT_W-1:0]   count_q, count_d;
  logic [kcec_pkg::TICK_W-1:0]  elapsed_q, elapsed_d, elapsed_inc;
  kcec_pkg::outcome_e           outcome_q;
  logic [kcec_pkg::MAX_CODE_CHARS-1:0] char_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q     <= '0;
      code_len_q <= '0;
      timeout_q  <= kcec_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (kcec_pkg::cfg_idx_e'(cfg_index_i))
        kcec_pkg::CFG_CODE_FIRST: code_q[63:0]   <= cfg_data_i;
        kcec_pkg::CFG_CODE_REST:  code_q[119:64] <= cfg_data_i[55:0];
        kcec_pkg::CFG_CODE_LEN:   code_len_q     <= cfg_data_i[kcec_pkg::CNT_W-1:0];
        kcec_pkg::CFG_TIMEOUT:    timeout_q      <= cfg_data_i[kcec_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // entry buffer: each slot written only when it is the append position
  for (genvar g = 0; g < kcec_pkg::MAX_CODE_CHARS; g++) begin : g_entry
    always_ff @(posedge clk_i) begin
      if (cmd_i.append && count_q == g[kcec_pkg::CNT_W-1:0]) begin
        entry_q[g] <= key_i;
      end
    end
    // slots at or above the fill count do not take part
    assign char_ok[g] = (count_q <= g[kcec_pkg::CNT_W-1:0]) ||
                        (entry_q[g] == code_q[g*kcec_pkg::KEY_W +: kcec_pkg::KEY_W]);
  end

  assign elapsed_inc = elapsed_q + 1'b1;

  always_comb begin
    count_d   = count_q;
    elapsed_d = elapsed_q;
    if (cmd_i.clear_attempt) begin
      count_d   = '0;
      elapsed_d = '0;
    end else begin
      if (cmd_i.append)      count_d   = count_q + 1'b1;
      if (cmd_i.delete_char) count_d   = count_q - 1'b1;
      if (cmd_i.tick)        elapsed_d = elapsed_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      elapsed_q <= '0;
    end else begin
      count_q   <= count_d;
      elapsed_q <= elapsed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      outcome_q <= cmd_i.result;
    end
  end

  assign stat_o.timeout_hit = (elapsed_inc >= timeout_q);
  assign stat_o.code_match  = (count_q == code_len_q) && (&char_ok);
  assign stat_o.buf_full    = (count_q >= kcec_pkg::CAPACITY_CNT);
  assign stat_o.buf_empty   = (count_q == '0);
  assign outcome_o          = outcome_q;

endmodule

`default_nettype wire

[design/kcec_ctrl.sv]
// ----------------------------------------------------------------------------
// kcec_ctrl
// Controller: decodes each item into datapath commands, tracks the result slot.
// ----------------------------------------------------------------------------
`default_nettype none

module kcec_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_kind_i,
  input  wire logic [kcec_pkg::KEY_W-1:0]  in_key_i,
  output logic                             in_stall_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  input  wire kcec_pkg::stat_t             stat_i,
  output kcec_pkg::cmd_t                   cmd_o
);

  kcec_pkg::state_e state_q, state_d;
  logic accept;
  logic has_result;
  logic is_key;

  // input waits only while a result sits unread
  assign in_stall_o = (state_q == kcec_pkg::ST_HOLD) && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_key     = !in_kind_i && (in_key_i != kcec_pkg::KEY_NONE);
  assign has_result = in_kind_i ? stat_i.timeout_hit
                                : (in_key_i == kcec_pkg::KEY_CONFIRM);

  always_comb begin
    state_d = state_q;
    case (state_q)
      kcec_pkg::ST_IDLE: begin
        if (accept && has_result) state_d = kcec_pkg::ST_HOLD;
      end
      kcec_pkg::ST_HOLD: begin
        if (!out_stall_i) begin
          state_d = (accept && has_result) ? kcec_pkg::ST_HOLD : kcec_pkg::ST_IDLE;
        end
      end
      default: state_d = kcec_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kcec_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.result = kcec_pkg::OUT_MATCH;
    if (accept) begin
      if (in_kind_i) begin
        cmd_o.tick = 1'b1;
        if (stat_i.timeout_hit) begin
          cmd_o.clear_attempt = 1'b1;
          cmd_o.load_result   = 1'b1;
          cmd_o.result        = kcec_pkg::OUT_TIMEOUT;
        end
      end else if (is_key) begin
        case (in_key_i)
          kcec_pkg::KEY_DELETE: begin
            cmd_o.delete_char = !stat_i.buf_empty;
          end
          kcec_pkg::KEY_CONFIRM: begin
            cmd_o.clear_attempt = 1'b1;
            cmd_o.load_result   = 1'b1;
            cmd_o.result = stat_i.code_match ? kcec_pkg::OUT_MATCH
                                             : kcec_pkg::OUT_MISMATCH;
          end
          default: begin
            cmd_o.append = !stat_i.buf_full;
          end
        endcase
      end
    end
  end

  assign out_valid_o = (state_q == kcec_pkg::ST_HOLD);

endmodule

`default_nettype wire

[design/keypad_code_entry_checker_top.sv]
// ----------------------------------------------------------------------------
// keypad_code_entry_checker_top
// Keypad code lock checker: collects key presses, checks the code on '#',
// reports a timeout after the configured number of ticks.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   in      | input     | in_valid_i / in_stall_o | in_kind_i, in_key_i
//   out     | output    | out_valid_o/out_stall_i | out_outcome_o
//   cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// The whole entry compare is one parallel 15-byte compare, so one item
// can be taken each cycle while the input does not stall.
// A result appears in the output register the cycle after its item.
// Input stalls only while a result is held and the output side stalls.
// Reset clears the counters and loads the default configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_code_entry_checker_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             in_kind_i,
  input  wire logic [kcec_pkg::KEY_W-1:0]       in_key_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [1:0]                            out_outcome_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [kcec_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [kcec_pkg::CFG_W-1:0]       cfg_data_i
);

  kcec_pkg::cmd_t  cmd;
  kcec_pkg::stat_t stat;

  kcec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_kind_i),
    .in_key_i    (in_key_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  kcec_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .key_i       (in_key_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .outcome_o   (out_outcome_o)
  );

endmodule

`default_nettype wire
